// File: rtl/blg_pkg.sv
// ----------------------------------------------------------------------------
// blg_pkg: shared types and constants of the battery level gauge
// Field widths, register codes, breakpoint tables, the segment lookup and
// the request/response structs of the serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package blg_pkg;

  localparam int ADC_W      = 12;
  localparam int SCALE_W    = 24;
  localparam int WEIGHT_W   = 9;
  localparam int PCT_W      = 7;
  localparam int MV_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int MCAND_W  = 24;
  localparam int MPLIER_W = 12;
  localparam int PROD_W   = MCAND_W + MPLIER_W;
  localparam int NBITS_W  = 4;

  localparam int OFF_W  = 10;
  localparam int DP_W   = 5;
  localparam int DV_W   = 10;
  localparam int DVD_W  = 14;
  localparam int QUOT_W = 5;
  localparam int QCNT_W = 3;

  localparam int GAUGE_POINTS = 7;

  localparam logic [SCALE_W-1:0]  VOLT_SCALE_RST   = 24'd276432;
  localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 9'd253;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE        = 9'd256;

  localparam logic [NBITS_W-1:0] NBITS_ADC = 4'd12;
  localparam logic [NBITS_W-1:0] NBITS_DP  = 4'd5;
  localparam logic [NBITS_W-1:0] NBITS_PCT = 4'd7;
  localparam logic [QCNT_W-1:0]  QUOT_STEPS = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_SCALE    = 2'd0,
    REG_SMOOTH_WEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [MV_W-1:0] BP_MV [GAUGE_POINTS] = '{
    16'd10500, 16'd11180, 16'd11390, 16'd11620, 16'd12070, 16'd12330, 16'd12600
  };
  localparam logic [PCT_W-1:0] BP_PCT [GAUGE_POINTS] = '{
    7'd0, 7'd20, 7'd40, 7'd60, 7'd80, 7'd90, 7'd100
  };
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic [PCT_W-1:0] base;
    logic [DP_W-1:0]  dp;
    logic [DV_W-1:0]  dv;
    logic [OFF_W-1:0] off;
  } seg_t;

  typedef struct packed {
    logic                start;
    logic                accum;
    logic [MCAND_W-1:0]  mcand;
    logic [MPLIER_W-1:0] mplier;
    logic [NBITS_W-1:0]  nbits;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Picks the interpolation segment for a voltage. Outside the table the
  // slope is zero and the divisor one, so the quotient comes out zero.
  function automatic seg_t seg_lookup(input logic [MV_W-1:0] mv);
    seg_t             s;
    logic             found;
    logic [MV_W-1:0]  dv_full;
    logic [MV_W-1:0]  off_full;
    logic [PCT_W-1:0] dp_full;
    s        = '{base: '0, dp: '0, dv: DV_W'(1), off: '0};
    found    = 1'b0;
    dv_full  = '0;
    off_full = '0;
    dp_full  = '0;
    if (mv < BP_MV[0]) begin
      s.base = '0;
    end else if (mv > BP_MV[GAUGE_POINTS-1]) begin
      s.base = PCT_FULL;
    end else begin
      for (int i = 1; i < GAUGE_POINTS; i++) begin
        if (!found && (mv <= BP_MV[i])) begin
          found    = 1'b1;
          dv_full  = BP_MV[i] - BP_MV[i-1];
          off_full = mv - BP_MV[i-1];
          dp_full  = BP_PCT[i] - BP_PCT[i-1];
          s.base   = BP_PCT[i-1];
          s.dp     = dp_full[DP_W-1:0];
          s.dv     = dv_full[DV_W-1:0];
          s.off    = off_full[OFF_W-1:0];
        end
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/battery_level_gauge_unit.sv
// ----------------------------------------------------------------------------
// battery_level_gauge_unit: ADC sample to battery voltage and charge level
// Scales a sample to millivolts, interpolates a charge percentage over fixed
// breakpoints and smooths it with a programmable weight.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_adc_sample) takes one
// sample per transfer. The result channel (out_valid, out_stall and the
// three result fields) gives one result per sample, in order. The register
// port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; index 0
// is the Q16 voltage scale, index 1 the Q8 smoothing weight, other indexes
// are ignored. Write registers only while no sample is in flight.
// The datapath has one serial multiplier for four products (of 12, 5, 7 and
// 7 multiplier bits) and a serial divider for five quotient bits, with a
// registered handoff for each of seven steps: the voltage load, the segment
// lookup, the divider start, the two smoothing starts, the level load and
// the result load. A new sample is taken only once the previous result has
// been loaded into the output register.
// Reset clears the smoother, so the first sample after reset gives a level
// equal to its raw percentage. A stalled result is held in the output
// register; the next sample is still taken and waits, finished, until the
// output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_gauge_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [blg_pkg::ADC_W-1:0]      in_adc_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [blg_pkg::PCT_W-1:0]      out_level_percent,
  output logic [blg_pkg::PCT_W-1:0]      out_raw_percent,
  output logic [blg_pkg::MV_W-1:0]       out_battery_mv,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [blg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MV    = 8'b00000010,
    S_SEG   = 8'b00000100,
    S_SCALE = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_SMA   = 8'b00100000,
    S_SMB   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SCALE_W-1:0]   volt_scale_r, volt_scale_nxt;
  logic [WEIGHT_W-1:0]  weight_r, weight_nxt;
  logic [PCT_W-1:0]     smooth_r, smooth_nxt;
  logic                 primed_r, primed_nxt;
  logic [MV_W-1:0]      mv_r, mv_nxt;
  logic [PCT_W-1:0]     base_r, base_nxt;
  logic [DV_W-1:0]      dv_r, dv_nxt;
  logic [PCT_W-1:0]     raw_r, raw_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0]     out_level_r, out_level_nxt;
  logic [PCT_W-1:0]     out_raw_r, out_raw_nxt;
  logic [MV_W-1:0]      out_mv_r, out_mv_nxt;

  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  seg_t                 seg;
  logic [WEIGHT_W-1:0]  w_eff;
  logic [WEIGHT_W-1:0]  w_rest;
  logic [PCT_W-1:0]     prev_lvl;
  logic [PCT_W-1:0]     div_raw;

  blg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  blg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign seg      = seg_lookup(mv_r);
  assign w_eff    = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign w_rest   = WEIGHT_ONE - w_eff;
  assign prev_lvl = primed_r ? smooth_r : raw_r;
  assign div_raw  = base_r + {{(PCT_W-QUOT_W){1'b0}}, div_rsp.quot};

  always_comb begin
    volt_scale_nxt = volt_scale_r;
    weight_nxt     = weight_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VOLT_SCALE:    volt_scale_nxt = cfg_data[SCALE_W-1:0];
        REG_SMOOTH_WEIGHT: weight_nxt     = cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    smooth_nxt    = smooth_r;
    primed_nxt    = primed_r;
    mv_nxt        = mv_r;
    base_nxt      = base_r;
    dv_nxt        = dv_r;
    raw_nxt       = raw_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_level_nxt = out_level_r;
    out_raw_nxt   = out_raw_r;
    out_mv_nxt    = out_mv_r;
    mul_req       = '0;
    div_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = volt_scale_r;
          mul_req.mplier = in_adc_sample;
          mul_req.nbits  = NBITS_ADC;
          state_nxt      = S_MV;
        end
      end
      S_MV: begin
        if (mul_rsp.done) begin
          if (mul_rsp.prod[PROD_W-1:2*MV_W] != '0) begin
            mv_nxt = '1;
          end else begin
            mv_nxt = mul_rsp.prod[2*MV_W-1:MV_W];
          end
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        base_nxt       = seg.base;
        dv_nxt         = seg.dv;
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-OFF_W){1'b0}}, seg.off};
        mul_req.mplier = {{(MPLIER_W-DP_W){1'b0}}, seg.dp};
        mul_req.nbits  = NBITS_DP;
        state_nxt      = S_SCALE;
      end
      S_SCALE: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.prod[DVD_W-1:0];
          div_req.divisor  = dv_r;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          raw_nxt        = div_raw;
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{(MCAND_W-WEIGHT_W){1'b0}}, w_eff};
          mul_req.mplier = {{(MPLIER_W-PCT_W){1'b0}}, div_raw};
          mul_req.nbits  = NBITS_PCT;
          state_nxt      = S_SMA;
        end
      end
      S_SMA: begin
        if (mul_rsp.done) begin
          mul_req.start  = 1'b1;
          mul_req.accum  = 1'b1;
          mul_req.mcand  = {{(MCAND_W-WEIGHT_W){1'b0}}, w_rest};
          mul_req.mplier = {{(MPLIER_W-PCT_W){1'b0}}, prev_lvl};
          mul_req.nbits  = NBITS_PCT;
          state_nxt      = S_SMB;
        end
      end
      S_SMB: begin
        if (mul_rsp.done) begin
          smooth_nxt = mul_rsp.prod[PCT_W+7:8];
          primed_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = smooth_r;
          out_raw_nxt   = raw_r;
          out_mv_nxt    = mv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      volt_scale_r <= VOLT_SCALE_RST;
      weight_r     <= SMOOTH_WEIGHT_RST;
      smooth_r     <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      volt_scale_r <= volt_scale_nxt;
      weight_r     <= weight_nxt;
      smooth_r     <= smooth_nxt;
      primed_r     <= primed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_r        <= mv_nxt;
    base_r      <= base_nxt;
    dv_r        <= dv_nxt;
    raw_r       <= raw_nxt;
    out_level_r <= out_level_nxt;
    out_raw_r   <= out_raw_nxt;
    out_mv_r    <= out_mv_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_level_percent = out_level_r;
  assign out_raw_percent   = out_raw_r;
  assign out_battery_mv    = out_mv_r;

  a_idle_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mul_rsp.busy && !div_rsp.busy)
    else $error("Arithmetic unit still busy while the gauge is idle.");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_raw_r <= PCT_FULL) && (out_level_r <= PCT_FULL))
    else $error("Percentage result above full scale.");

  a_primed_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> primed_r)
    else $error("Result presented before the smoother was primed.");

  a_primed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("Smoother lost its primed state without a reset.");

endmodule

`default_nettype wire

// File: rtl/blg_mul.sv
// ----------------------------------------------------------------------------
// blg_mul: shared bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle, optionally adding onto the previous
// product so that two products can be summed.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  blg_pkg::mul_req_t req,
  output blg_pkg::mul_rsp_t rsp
);
  import blg_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [NBITS_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [MPLIER_W-1:0] mplier_r, mplier_nxt;
  logic [PROD_W-1:0]   acc_r, acc_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = req.nbits;
      mcand_nxt  = {{(PROD_W-MCAND_W){1'b0}}, req.mcand};
      mplier_nxt = req.mplier;
      acc_nxt    = req.accum ? acc_r : '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[MPLIER_W-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == NBITS_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("Multiplier started while a product was in progress.");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("Multiplier busy with an empty bit count.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("Multiplier done without a finished product.");

endmodule

`default_nettype wire

// File: rtl/blg_div.sv
// ----------------------------------------------------------------------------
// blg_div: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first, for quotients
// known to fit in the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module blg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  blg_pkg::div_req_t req,
  output blg_pkg::div_rsp_t rsp
);
  import blg_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  dsr_r, dsr_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QUOT_STEPS;
      rem_nxt  = req.dividend;
      dsr_nxt  = {req.divisor, {(DVD_W-DV_W){1'b0}}};
      quot_nxt = '0;
    end else if (busy_r) begin
      if (rem_r >= dsr_r) begin
        rem_nxt  = rem_r - dsr_r;
        quot_nxt = {quot_r[QUOT_W-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[QUOT_W-2:0], 1'b0};
      end
      dsr_nxt = {1'b0, dsr_r[DVD_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("Divider started while a quotient was in progress.");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("Divider busy with an empty step count.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("Divider done without a finished quotient.");

endmodule

`default_nettype wire
